// ===== hdl/egcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the extended gcd block: operand and coefficient widths,
// sequencer states and the command/status structs of the divider unit.
// No dependencies.

package egcd_pkg;

  localparam int WIDTH      = 31;
  localparam int COEF_WIDTH = WIDTH + 1;
  localparam int CNT_WIDTH  = $clog2(WIDTH);

  typedef logic [WIDTH-1:0]             operand_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic [CNT_WIDTH-1:0]         count_t;

  localparam count_t CNT_LAST = CNT_WIDTH'(WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } state_t;

  // Start of one quotient step: dividend, divisor and the coefficients that
  // get multiplied by the quotient.
  typedef struct packed {
    logic     start;
    operand_t dividend;
    operand_t divisor;
    coef_t    coef_x;
    coef_t    coef_y;
  } div_cmd_t;

  // End of one quotient step: remainder and quotient times each coefficient.
  typedef struct packed {
    logic     done;
    operand_t remainder;
    coef_t    prod_x;
    coef_t    prod_y;
  } div_res_t;

endpackage

`default_nettype wire

// ===== hdl/egcd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the extended gcd block: one for operand
// beats and one for result beats. Depends on egcd_pkg.

interface egcd_in_if;
  logic                valid;
  logic                ready;
  egcd_pkg::operand_t  first_value;
  egcd_pkg::operand_t  second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface egcd_out_if;
  logic                valid;
  logic                ready;
  egcd_pkg::coef_t     coef_first;
  egcd_pkg::coef_t     coef_second;
  egcd_pkg::operand_t  divisor_out;

  modport source (output valid, output coef_first, output coef_second,
                  output divisor_out, input ready);
  modport sink   (input valid, input coef_first, input coef_second,
                  input divisor_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/egcd_div_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared quotient-step unit: restoring division one quotient bit per cycle,
// with the quotient times two coefficients built alongside by Horner steps.
// Depends on egcd_pkg.

module egcd_div_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire egcd_pkg::div_cmd_t cmd,
  output egcd_pkg::div_res_t    res
);

  logic                busy;
  logic                done;
  egcd_pkg::count_t    cnt;
  egcd_pkg::operand_t  dvd;
  egcd_pkg::operand_t  dsr;
  egcd_pkg::operand_t  rem;
  egcd_pkg::coef_t     cx;
  egcd_pkg::coef_t     cy;
  egcd_pkg::coef_t     px;
  egcd_pkg::coef_t     py;

  logic [egcd_pkg::WIDTH:0] shifted;
  logic [egcd_pkg::WIDTH:0] diff;
  logic                     qbit;
  egcd_pkg::operand_t       rem_next;
  egcd_pkg::coef_t          px_next;
  egcd_pkg::coef_t          py_next;

  always_comb begin
    shifted  = {rem, dvd[egcd_pkg::WIDTH-1]};
    diff     = shifted - {1'b0, dsr};
    qbit     = ~diff[egcd_pkg::WIDTH];
    rem_next = qbit ? diff[egcd_pkg::WIDTH-1:0] : shifted[egcd_pkg::WIDTH-1:0];
    // Coefficient products wrap at the coefficient width, as the final
    // values are known to fit.
    px_next  = (px <<< 1) + (qbit ? cx : '0);
    py_next  = (py <<< 1) + (qbit ? cy : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == egcd_pkg::CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd <= cmd.dividend;
      dsr <= cmd.divisor;
      cx  <= cmd.coef_x;
      cy  <= cmd.coef_y;
      rem <= '0;
      px  <= '0;
      py  <= '0;
    end else if (busy) begin
      dvd <= {dvd[egcd_pkg::WIDTH-2:0], qbit};
      rem <= rem_next;
      px  <= px_next;
      py  <= py_next;
    end
  end

  assign res.done      = done;
  assign res.remainder = rem;
  assign res.prod_x    = px;
  assign res.prod_y    = py;

endmodule

`default_nettype wire

// ===== hdl/extended_gcd_bezout.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the extended gcd block: sequencer, operand and coefficient
// registers, and result register. Depends on egcd_pkg, egcd_if, egcd_div_unit.
//
// Usage:
// Operand beats arrive on the operands channel (first_value a, second_value b)
// and one result beat per operand beat leaves on the result channel: Bezout
// coefficients coef_first x and coef_second y with a*x + b*y = gcd(a, b), and
// the gcd on divisor_out. If b is zero the result is x = 1, y = 0, gcd = a.
// The block works on one pair at a time. operands.ready is high only while the
// sequencer is idle; it drops for the whole run of the algorithm.
// Each Euclid step starts the shared divider, runs restoring division (one
// quotient bit per cycle, with the quotient times both coefficients
// accumulated in the same cycles), and then updates the remainder and
// coefficient registers. The number of quotient steps n is at most about 45
// for 31-bit operands and is typically near 15 to 20. A new pair is
// accepted only once the previous run ends, so the bit-serial divider sets
// how fast pairs pass through.
// The result sits in an output register, so a new operand beat is accepted
// while the previous result waits. If the receiver stalls, a finished
// computation waits in its final check until the result register frees.
// Synchronous reset returns the sequencer to idle and drops result.valid.

module extended_gcd_bezout (
  input  wire logic   clk,
  input  wire logic   rst,
  egcd_in_if.sink     operands,
  egcd_out_if.source  result
);

  egcd_pkg::state_t    state;
  egcd_pkg::state_t    state_next;

  egcd_pkg::operand_t  a_reg;
  egcd_pkg::operand_t  b_reg;
  egcd_pkg::coef_t     xa;
  egcd_pkg::coef_t     ya;
  egcd_pkg::coef_t     xb;
  egcd_pkg::coef_t     yb;

  logic                out_valid;
  egcd_pkg::coef_t     out_x;
  egcd_pkg::coef_t     out_y;
  egcd_pkg::operand_t  out_gcd;

  logic                in_take;
  logic                b_zero;
  logic                out_free;
  logic                out_load;

  egcd_pkg::div_cmd_t  div_cmd;
  egcd_pkg::div_res_t  div_res;

  egcd_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .res (div_res)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    b_zero     = (b_reg == '0);
    out_free   = !out_valid || result.ready;
    in_take    = 1'b0;
    out_load   = 1'b0;
    state_next = state;
    unique case (state)
      egcd_pkg::ST_IDLE: begin
        in_take = operands.valid;
        if (operands.valid) begin
          state_next = egcd_pkg::ST_CHECK;
        end
      end
      egcd_pkg::ST_CHECK: begin
        // A zero remainder ends the algorithm; otherwise run one more step.
        if (!b_zero) begin
          state_next = egcd_pkg::ST_DIV;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = egcd_pkg::ST_IDLE;
        end
      end
      egcd_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_next = egcd_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  assign operands.ready = (state == egcd_pkg::ST_IDLE);

  always_comb begin
    div_cmd.start    = (state == egcd_pkg::ST_CHECK) && !b_zero;
    div_cmd.dividend = a_reg;
    div_cmd.divisor  = b_reg;
    div_cmd.coef_x   = xb;
    div_cmd.coef_y   = yb;
  end

  // Working registers: load on an operand beat, shift down one step when
  // the divider finishes.
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_reg <= operands.first_value;
      b_reg <= operands.second_value;
      xa    <= egcd_pkg::COEF_WIDTH'(1);
      ya    <= '0;
      xb    <= '0;
      yb    <= egcd_pkg::COEF_WIDTH'(1);
    end else if (div_res.done) begin
      a_reg <= b_reg;
      b_reg <= div_res.remainder;
      xa    <= xb;
      ya    <= yb;
      xb    <= xa - div_res.prod_x;
      yb    <= ya - div_res.prod_y;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x   <= xa;
      out_y   <= ya;
      out_gcd <= a_reg;
    end
  end

  assign result.valid       = out_valid;
  assign result.coef_first  = out_x;
  assign result.coef_second = out_y;
  assign result.divisor_out = out_gcd;

  // The divider only reports completion while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == egcd_pkg::ST_DIV)
    else $error("divider finished outside a division step");

  // Each step must leave a remainder below its divisor.
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> div_res.remainder < b_reg)
    else $error("remainder not below divisor");

  // An operand beat always starts with the zero check.
  a_take_check: assert property (@(posedge clk) disable iff (rst)
    (operands.valid && operands.ready) |=> state == egcd_pkg::ST_CHECK)
    else $error("operand beat did not start a run");

  // A new result only appears after a check that found a zero remainder.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !$past(result.valid)) |->
      ($past(state) == egcd_pkg::ST_CHECK && $past(b_reg) == '0))
    else $error("result appeared without a finished run");

endmodule

`default_nettype wire
